/* design/geo_pkg.sv */
package geo_pkg;

   // Frame geometry limits and accumulator width
   localparam int MaxWidth   = 4096;
   localparam int MaxHeight  = 4096;
   localparam int SumBits    = 48;

   localparam int ColBits    = $clog2(MaxWidth);
   localparam int RowBits    = $clog2(MaxHeight);

   // Fixed field widths
   localparam int PixelBits  = 8;
   localparam int DimBits    = 13;
   localparam int EnergyBits = 48;
   localparam int SqBits     = 2 * PixelBits;

   // CSR map
   localparam int CsrIndexBits = 4;
   localparam logic [CsrIndexBits-1:0] CsrImageWidth  = CsrIndexBits'(0);
   localparam logic [CsrIndexBits-1:0] CsrImageHeight = CsrIndexBits'(1);

   localparam logic [DimBits-1:0] DimReset = DimBits'(64);

   // Squared absolute difference of two pixels
   function automatic logic [SqBits-1:0] sq_diff(input logic [PixelBits-1:0] a,
                                                 input logic [PixelBits-1:0] b);
      logic [PixelBits-1:0] d;
      d = (a >= b) ? (a - b) : (b - a);
      return SqBits'(d) * SqBits'(d);
   endfunction

   // Saturating accumulate of one squared step
   function automatic logic [SumBits-1:0] sat_add(input logic [SumBits-1:0] acc,
                                                  input logic [SqBits-1:0]  add);
      logic [SumBits:0] t;
      t = {1'b0, acc} + (SumBits + 1)'(add);
      return t[SumBits] ? {SumBits{1'b1}} : t[SumBits-1:0];
   endfunction

endpackage

/* design/geo_ram.sv */
module geo_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // read-first: a read and write to the same address return the old word
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* design/gradient_energy_orientation.sv */
// Gradient energy orientation classifier. Feed one 8-bit grey pixel per
// transaction in raster order; the block accepts one pixel every clock
// while req_stall is low. The result of a frame passes from the line store
// read through the accumulate stage into the output register.
// Only the last pixel of a frame produces a result transaction: the two
// saturating squared-step energies (to the pixel above and to the left) and
// line_is_horizontal, set when the row step energy is strictly larger.
// Width and height are clamped to 2..4096 and should be written between
// frames; a change takes effect with the next accepted pixel. The line
// store needs no clearing after reset: the first row of each frame writes
// every column before the second row reads it. req_stall rises only while
// a finished result waits in the output register and the next frame-end
// result is ready behind it.
module gradient_energy_orientation (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [geo_pkg::PixelBits-1:0]       req_pixel,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [geo_pkg::EnergyBits-1:0]      rsp_row_step_energy,
   output logic [geo_pkg::EnergyBits-1:0]      rsp_column_step_energy,
   output logic                                rsp_line_is_horizontal,

   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [geo_pkg::CsrIndexBits-1:0]    csr_index,
   input  logic [geo_pkg::DimBits-1:0]         csr_data
);

   localparam int ColBits   = geo_pkg::ColBits;
   localparam int RowBits   = geo_pkg::RowBits;
   localparam int PixelBits = geo_pkg::PixelBits;
   localparam int DimBits   = geo_pkg::DimBits;
   localparam int SumBits   = geo_pkg::SumBits;

   // ---------------- CSRs ----------------
   logic [DimBits-1:0] width_ff,  width_in;
   logic [DimBits-1:0] height_ff, height_in;

   assign csr_ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            geo_pkg::CsrImageWidth:  width_in  = csr_data;
            geo_pkg::CsrImageHeight: height_in = csr_data;
            default: ;
         endcase
      end
   end

   // Clamped geometry, as last-column / last-row indices
   logic [ColBits:0]   width_lim;
   logic [RowBits:0]   height_lim;
   logic [ColBits-1:0] last_col_idx;
   logic [RowBits-1:0] last_row_idx;

   always_comb begin
      if (width_ff < DimBits'(2)) begin
         width_lim = (ColBits + 1)'(2);
      end else if (32'(width_ff) > geo_pkg::MaxWidth) begin
         width_lim = (ColBits + 1)'(geo_pkg::MaxWidth);
      end else begin
         width_lim = (ColBits + 1)'(width_ff);
      end
      if (height_ff < DimBits'(2)) begin
         height_lim = (RowBits + 1)'(2);
      end else if (32'(height_ff) > geo_pkg::MaxHeight) begin
         height_lim = (RowBits + 1)'(geo_pkg::MaxHeight);
      end else begin
         height_lim = (RowBits + 1)'(height_ff);
      end
      last_col_idx = ColBits'(width_lim - (ColBits + 1)'(1));
      last_row_idx = RowBits'(height_lim - (RowBits + 1)'(1));
   end

   // ---------------- Stage A: accept, line store access ----------------
   // The pixel at column c reads the entry the previous row left there and
   // overwrites it in the same cycle; the RAM is read-first, so no bypass.
   logic [ColBits-1:0]   col_ff,  col_in;
   logic [RowBits-1:0]   row_ff,  row_in;
   logic [PixelBits-1:0] left_ff, left_in;
   logic                 req_fire;
   logic                 end_of_row;
   logic                 end_of_frame;
   logic [PixelBits-1:0] up_pixel;

   assign req_fire     = req_valid && !req_stall;
   assign end_of_row   = (col_ff >= last_col_idx);
   assign end_of_frame = end_of_row && (row_ff >= last_row_idx);

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      left_in = left_ff;
      if (req_fire) begin
         left_in = req_pixel;
         if (end_of_row) begin
            col_in = '0;
            row_in = end_of_frame ? '0 : row_ff + RowBits'(1);
         end else begin
            col_in = col_ff + ColBits'(1);
         end
      end
   end

   geo_ram #(
      .WIDTH (PixelBits),
      .DEPTH (geo_pkg::MaxWidth)
   ) u_line_store (
      .clock (clock),
      .we    (req_fire),
      .waddr (col_ff),
      .wdata (req_pixel),
      .re    (req_fire),
      .raddr (col_ff),
      .rdata (up_pixel)
   );

   // ---------------- Stage B: accumulate ----------------
   logic                 b_vld_ff,      b_vld_in;
   logic [PixelBits-1:0] b_pix_ff;
   logic [PixelBits-1:0] b_left_ff;
   logic                 b_has_up_ff;
   logic                 b_has_left_ff;
   logic                 b_last_ff;
   logic                 b_blocked;
   logic                 b_fire;
   logic                 rsp_load;

   logic [SumBits-1:0]   vsum_ff, vsum_in;
   logic [SumBits-1:0]   hsum_ff, hsum_in;
   logic [SumBits-1:0]   vsum_nxt;
   logic [SumBits-1:0]   hsum_nxt;

   // A frame-end item waits here while the output register is still full
   assign b_blocked = b_vld_ff && b_last_ff && rsp_valid && rsp_stall;
   assign b_fire    = b_vld_ff && !b_blocked;
   assign rsp_load  = b_fire && b_last_ff;
   assign req_stall = b_blocked;
   assign b_vld_in  = req_fire || (b_vld_ff && b_blocked);

   always_comb begin
      vsum_nxt = b_has_up_ff ?
                 geo_pkg::sat_add(vsum_ff, geo_pkg::sq_diff(b_pix_ff, up_pixel)) : vsum_ff;
      hsum_nxt = b_has_left_ff ?
                 geo_pkg::sat_add(hsum_ff, geo_pkg::sq_diff(b_pix_ff, b_left_ff)) : hsum_ff;
      vsum_in  = vsum_ff;
      hsum_in  = hsum_ff;
      if (b_fire) begin
         vsum_in = b_last_ff ? '0 : vsum_nxt;
         hsum_in = b_last_ff ? '0 : hsum_nxt;
      end
   end

   // ---------------- Output register ----------------
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [geo_pkg::EnergyBits-1:0]    rsp_row_ff;
   logic [geo_pkg::EnergyBits-1:0]    rsp_col_ff;
   logic                              rsp_horiz_ff;

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_row_step_energy    = rsp_row_ff;
   assign rsp_column_step_energy = rsp_col_ff;
   assign rsp_line_is_horizontal = rsp_horiz_ff;

   // ---------------- Registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= geo_pkg::DimReset;
         height_ff    <= geo_pkg::DimReset;
         col_ff       <= '0;
         row_ff       <= '0;
         left_ff      <= '0;
         b_vld_ff     <= 1'b0;
         vsum_ff      <= '0;
         hsum_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         left_ff      <= left_in;
         b_vld_ff     <= b_vld_in;
         vsum_ff      <= vsum_in;
         hsum_ff      <= hsum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         b_pix_ff      <= req_pixel;
         b_left_ff     <= left_ff;
         b_has_up_ff   <= (row_ff != '0);
         b_has_left_ff <= (col_ff != '0);
         b_last_ff     <= end_of_frame;
      end
      if (rsp_load) begin
         rsp_row_ff   <= geo_pkg::EnergyBits'(vsum_nxt);
         rsp_col_ff   <= geo_pkg::EnergyBits'(hsum_nxt);
         rsp_horiz_ff <= (vsum_nxt > hsum_nxt);
      end
   end

   // ---------------- Assertions ----------------
   a_stall_only_on_frame_end: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (b_vld_ff && b_last_ff && rsp_valid_ff))
      else $error("input stalled without a pending frame-end result");

   a_sums_cleared_after_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (vsum_ff == '0 && hsum_ff == '0))
      else $error("energy sums not cleared after frame end");

   a_result_from_frame_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && rsp_stall)) |->
         $past(b_vld_ff && b_last_ff))
      else $error("result appeared without a frame-end item");

   a_blocked_holds_stage: assert property (@(posedge clock) disable iff (reset)
      b_blocked |=> (b_vld_ff && b_last_ff && $stable(b_pix_ff)))
      else $error("blocked accumulate stage lost its item");

endmodule
